// ===== hdl/msp_pkg.sv =====
// Shared types and constants of the multichannel servo pulse generator.
`timescale 1ns / 1ps

package msp_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam logic       OP_SET_ANGLE = 1'b0;
    localparam logic       OP_TICK      = 1'b1;

    localparam logic [1:0] CFG_MIN_PULSE    = 2'd0;
    localparam logic [1:0] CFG_MAX_PULSE    = 2'd1;
    localparam logic [1:0] CFG_FRAME_PERIOD = 2'd2;

    localparam logic [11:0] MIN_PULSE_RST    = 12'd1000;
    localparam logic [11:0] MAX_PULSE_RST    = 12'd2000;
    localparam logic [15:0] FRAME_PERIOD_RST = 16'd20000;
    localparam logic [11:0] MID_PULSE        = 12'd1500;

    localparam logic [15:0] MAX_ANGLE   = 16'd180;
    localparam logic [3:0]  MIN_PAYLOAD = 4'd3;

    // Division by 180 is a shift by two followed by a reciprocal multiply for 45.
    localparam logic [18:0] RECIP_45    = 19'd372828;
    localparam int          RECIP_SHIFT = 24;

    typedef struct packed {
        logic        operation;
        logic [3:0]  payload_length;
        logic [7:0]  channel;
        logic [15:0] angle;
    } in_beat_t;

    typedef struct packed {
        logic [3:0] pin_levels;
        logic       ack_valid;
        logic [7:0] ack_channel;
        logic       ack_ok;
        logic       frame_start;
    } out_beat_t;

    typedef struct packed {
        logic [11:0] min_pulse_us;
        logic [11:0] max_pulse_us;
        logic [15:0] frame_period_us;
    } cfg_t;

endpackage

// ===== hdl/multichannel_servo_pulse_generator_top.sv =====
// Top level of the multichannel servo pulse generator.
//
// The s_ channel takes one beat per item: a set-angle command or a one
// microsecond tick. Every input beat yields exactly one beat on the m_
// channel, in order. A tick beat reports the servo pin levels for that
// microsecond and flags the start of each frame; a command beat returns an
// acknowledge and repeats the last pin levels.
// The configuration port writes the minimum and maximum pulse widths and the
// frame period at one register per cycle; writes must be made while no beats
// are in flight, which the block itself does not enforce.
// An input register holds the item and the angle product, combinational logic
// updates the frame state, and the output register presents the result. One
// beat is taken in every cycle while the receiver does not stall.
// Reset restores the default configuration, sets every channel to the mid
// pulse width and starts at the first channel of a new frame.
// When the receiver stalls, the output register holds its beat and the input
// register can still take one more beat before s_ready drops.
`timescale 1ns / 1ps

module multichannel_servo_pulse_generator_top #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  msp_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output msp_pkg::out_beat_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata
);

    msp_pkg::cfg_t      cfg_reg;
    msp_pkg::cfg_t      cfg_next;
    msp_pkg::in_beat_t  item;
    msp_pkg::out_beat_t result;
    logic [19:0]        product;
    logic               advance;
    logic               step_en;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                msp_pkg::CFG_MIN_PULSE:    cfg_next.min_pulse_us    = cfg_wdata[11:0];
                msp_pkg::CFG_MAX_PULSE:    cfg_next.max_pulse_us    = cfg_wdata[11:0];
                msp_pkg::CFG_FRAME_PERIOD: cfg_next.frame_period_us = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse_us    <= msp_pkg::MIN_PULSE_RST;
            cfg_reg.max_pulse_us    <= msp_pkg::MAX_PULSE_RST;
            cfg_reg.frame_period_us <= msp_pkg::FRAME_PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    msp_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .advance (advance),
        .step_en (step_en),
        .item    (item),
        .product (product)
    );

    msp_frame_seq #(
        .CHANNELS (CHANNELS)
    ) u_frame_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item),
        .product (product),
        .cfg     (cfg_reg),
        .result  (result)
    );

    msp_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step_en),
        .result  (result),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hdl/msp_in_stage.sv =====
// Input register of the servo pulse generator, with the angle times span product.
`timescale 1ns / 1ps

module msp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  msp_pkg::in_beat_t s_data,
    input  msp_pkg::cfg_t     cfg,
    input  logic              advance,
    output logic              step_en,
    output msp_pkg::in_beat_t item,
    output logic [19:0]       product
);

    logic              valid_reg;
    logic              valid_next;
    msp_pkg::in_beat_t item_reg;
    logic [19:0]       product_reg;
    logic [11:0]       span;
    logic [7:0]        angle_clamped;
    logic              take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;
    assign step_en = valid_reg && advance;

    assign span = (cfg.max_pulse_us > cfg.min_pulse_us) ?
                  (cfg.max_pulse_us - cfg.min_pulse_us) : 12'd0;
    assign angle_clamped = (s_data.angle > msp_pkg::MAX_ANGLE) ?
                           msp_pkg::MAX_ANGLE[7:0] : s_data.angle[7:0];

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (step_en) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg    <= s_data;
            product_reg <= {8'd0, span} * {12'd0, angle_clamped};
        end
    end

    assign item    = item_reg;
    assign product = product_reg;

endmodule

// ===== hdl/msp_frame_seq.sv =====
// Frame sequencer: channel widths, frame timing state and per-beat result logic.
`timescale 1ns / 1ps

module msp_frame_seq #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  msp_pkg::in_beat_t  item,
    input  logic [19:0]        product,
    input  msp_pkg::cfg_t      cfg,
    output msp_pkg::out_beat_t result
);

    localparam int PH_W  = $clog2(CHANNELS + 1);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [PH_W-1:0] GAP_PHASE = PH_W'(CHANNELS);

    logic [11:0]     width_reg [CHANNELS];
    logic [PH_W-1:0] phase_reg;
    logic [PH_W-1:0] phase_next;
    logic [15:0]     tick_reg;
    logic [15:0]     tick_next;
    logic [15:0]     used_reg;
    logic [15:0]     used_next;
    logic [11:0]     cur_reg;
    logic [11:0]     cur_next;
    logic [3:0]      pins_reg;
    logic [3:0]      pins_next;

    logic [CHANNELS-1:0] nonzero;
    logic [36:0]         recip_prod;
    logic [11:0]         new_width;
    logic                cmd_ok;
    logic                cmd_write;

    logic            in_channel;
    logic [16:0]     used_sum;
    logic [15:0]     used_sat;
    logic [16:0]     gap_pos;
    logic            entry;
    logic [PH_W-1:0] start;
    logic [15:0]     used_entry;
    logic [PH_W-1:0] p_from;
    logic            f_from;
    logic [PH_W-1:0] p_zero;
    logic            f_zero;
    logic            do_run;
    logic            do_gap;
    logic [PH_W-1:0] run_p;
    logic            fs;
    logic [15:0]     used_after;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            nonzero[i] = (width_reg[i] != 12'd0);
        end
    end

    assign recip_prod = {1'b0, product[19:2]} * {18'd0, msp_pkg::RECIP_45};
    assign new_width  = cfg.min_pulse_us + recip_prod[msp_pkg::RECIP_SHIFT +: 12];
    assign cmd_ok     = (item.payload_length >= msp_pkg::MIN_PAYLOAD) &&
                        (item.channel < 8'(CHANNELS));
    assign cmd_write  = step_en && (item.operation == msp_pkg::OP_SET_ANGLE) && cmd_ok;

    assign in_channel = (phase_reg != GAP_PHASE);
    assign used_sum   = {1'b0, used_reg} + {5'd0, cur_reg};
    assign used_sat   = used_sum[16] ? 16'hFFFF : used_sum[15:0];
    assign gap_pos    = {1'b0, tick_reg} + {1'b0, used_reg};

    always_comb begin
        entry      = 1'b0;
        start      = phase_reg;
        used_entry = used_reg;
        p_from     = '0;
        f_from     = 1'b0;
        p_zero     = '0;
        f_zero     = 1'b0;
        do_run     = 1'b0;
        do_gap     = 1'b0;
        run_p      = phase_reg;
        fs         = 1'b0;
        used_after = used_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg + 16'd1;
        used_next  = used_reg;
        cur_next   = cur_reg;
        pins_next  = 4'd0;

        if (in_channel) begin
            if (tick_reg != 16'd0) begin
                if ({4'd0, cur_reg} <= tick_reg) begin
                    entry      = 1'b1;
                    start      = phase_reg + 1'b1;
                    used_entry = used_sat;
                end
            end else begin
                entry = 1'b1;
            end
        end else if (gap_pos >= {1'b0, cfg.frame_period_us}) begin
            entry = 1'b1;
            start = '0;
        end

        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (nonzero[i] && (i >= int'(start))) begin
                p_from = PH_W'(i);
                f_from = 1'b1;
            end
            if (nonzero[i]) begin
                p_zero = PH_W'(i);
                f_zero = 1'b1;
            end
        end

        if (entry) begin
            if (start == '0) begin
                fs         = 1'b1;
                used_after = 16'd0;
                if (f_zero) begin
                    do_run = 1'b1;
                    run_p  = p_zero;
                end else if (cfg.frame_period_us != 16'd0) begin
                    do_gap = 1'b1;
                end
            end else if (f_from) begin
                used_after = used_entry;
                do_run     = 1'b1;
                run_p      = p_from;
            end else if (cfg.frame_period_us > used_entry) begin
                used_after = used_entry;
                do_gap     = 1'b1;
            end else begin
                fs         = 1'b1;
                used_after = 16'd0;
                if (f_zero) begin
                    do_run = 1'b1;
                    run_p  = p_zero;
                end else if (cfg.frame_period_us != 16'd0) begin
                    do_gap = 1'b1;
                end
            end

            used_next = used_after;
            if (do_run) begin
                phase_next = run_p;
                tick_next  = 16'd1;
                cur_next   = width_reg[run_p[IDX_W-1:0]];
            end else if (do_gap) begin
                phase_next = GAP_PHASE;
                tick_next  = 16'd1;
            end else begin
                phase_next = '0;
                tick_next  = 16'd0;
            end
        end

        if (!entry || do_run) begin
            for (int b = 0; b < 4; b++) begin
                if (b < CHANNELS) begin
                    pins_next[b] = (do_run || in_channel) && (int'(run_p) == b);
                end
            end
        end
    end

    always_comb begin
        result = '0;
        if (item.operation == msp_pkg::OP_TICK) begin
            result.pin_levels  = pins_next;
            result.frame_start = fs;
        end else begin
            result.pin_levels = pins_reg;
            result.ack_valid  = 1'b1;
            result.ack_ok     = cmd_ok;
            if (item.payload_length >= msp_pkg::MIN_PAYLOAD) begin
                result.ack_channel = item.channel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            tick_reg  <= 16'd0;
            used_reg  <= 16'd0;
            cur_reg   <= 12'd0;
            pins_reg  <= 4'd0;
        end else if (step_en && (item.operation == msp_pkg::OP_TICK)) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            used_reg  <= used_next;
            cur_reg   <= cur_next;
            pins_reg  <= pins_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                width_reg[i] <= msp_pkg::MID_PULSE;
            end
        end else if (cmd_write) begin
            width_reg[item.channel[IDX_W-1:0]] <= new_width;
        end
    end

endmodule

// ===== hdl/msp_out_stage.sv =====
// Output register of the servo pulse generator.
`timescale 1ns / 1ps

module msp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  msp_pkg::out_beat_t result,
    output logic               advance,
    output logic               m_valid,
    input  logic               m_ready,
    output msp_pkg::out_beat_t m_data
);

    logic               valid_reg;
    logic               valid_next;
    msp_pkg::out_beat_t data_reg;

    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
